FILE: sv/sacb_pkg.sv
package sacb_pkg;

    localparam int          MAX_STREAMS_DEF = 32;
    localparam logic [31:0] MAX_WINDOW_DEF  = 32'd67108864;

    localparam logic [2:0] OP_OPEN    = 3'd0;
    localparam logic [2:0] OP_CLOSE   = 3'd1;
    localparam logic [2:0] OP_RESERVE = 3'd2;
    localparam logic [2:0] OP_ADJUST  = 3'd3;
    localparam logic [2:0] OP_RELEASE = 3'd4;

    localparam logic [1:0] ST_OK       = 2'd0;
    localparam logic [1:0] ST_REJECT   = 2'd1;
    localparam logic [1:0] ST_CAPACITY = 2'd2;

    localparam logic CFG_CREDIT_LIMIT = 1'b0;
    localparam logic CFG_STREAM_LIMIT = 1'b1;

    typedef struct packed {
        logic [2:0]  op;
        logic [31:0] sid;
        logic        local_creates;
        logic [1:0]  role;
        logic        direction;
        logic [31:0] amount;
        logic [31:0] release_amount;
    } req_t;

    typedef struct packed {
        logic [1:0]  status;
        logic [5:0]  active_count;
        logic [31:0] reserved_out;
        logic [31:0] reserved_in;
    } rsp_t;

    typedef struct packed {
        logic capture;
        logic commit;
    } cmd_t;

endpackage

FILE: sv/sacb_ctrl.sv
module sacb_ctrl (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              start,
    output logic              busy,
    output logic              done,
    output sacb_pkg::cmd_t    cmd
);
    import sacb_pkg::*;

    localparam logic ST_IDLE   = 1'b0;
    localparam logic ST_COMMIT = 1'b1;

    logic state_reg;
    logic state_next;
    logic done_reg;

    always_comb
    begin
        state_next  = state_reg;
        cmd.capture = 1'b0;
        cmd.commit  = 1'b0;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (start)
                begin
                    cmd.capture = 1'b1;
                    state_next  = ST_COMMIT;
                end
            end
            ST_COMMIT:
            begin
                cmd.commit = 1'b1;
                state_next = ST_IDLE;
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            done_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            done_reg  <= cmd.commit;
        end
    end

    assign busy = (state_reg == ST_COMMIT);
    assign done = done_reg;

endmodule

FILE: sv/sacb_dp.sv
module sacb_dp #(
    parameter int          MAX_STREAMS = sacb_pkg::MAX_STREAMS_DEF,
    parameter logic [31:0] MAX_WINDOW  = sacb_pkg::MAX_WINDOW_DEF
) (
    input  logic              clk,
    input  logic              rst_n,
    input  sacb_pkg::cmd_t    cmd,
    input  sacb_pkg::req_t    request,
    input  logic              cfg_we,
    input  logic              cfg_idx,
    input  logic [31:0]       cfg_data,
    output sacb_pkg::rsp_t    result
);
    import sacb_pkg::*;

    localparam int          IDX_W      = (MAX_STREAMS > 1) ? $clog2(MAX_STREAMS) : 1;
    localparam int          CNT_W      = $clog2(MAX_STREAMS + 1);
    localparam logic [5:0]  LIM_CAP    = (MAX_STREAMS < 32) ? 6'(MAX_STREAMS) : 6'd32;
    localparam logic [31:0] CREDIT_RST = (MAX_WINDOW < 32'd16777216) ? MAX_WINDOW
                                                                      : 32'd16777216;
    localparam logic [31:0] ID_LAST    = 32'hFFFF_FFFD;

    // configuration
    logic [31:0]      credit_limit_reg;
    logic [5:0]       stream_limit_reg;

    // admission state
    logic             role_latched_reg, role_latched_next;
    logic             latched_role_reg, latched_role_next;
    logic [31:0]      next_local_reg, next_local_next;
    logic [31:0]      next_peer_reg, next_peer_next;
    logic             local_spent_reg, local_spent_next;
    logic             peer_spent_reg, peer_spent_next;
    logic [31:0]      ids_reg [MAX_STREAMS];
    logic [31:0]      ids_next [MAX_STREAMS];
    logic [CNT_W-1:0] total_reg, total_next;
    logic [31:0]      res_out_reg, res_out_next;
    logic [31:0]      res_in_reg, res_in_next;

    // captured request and first-cycle results
    req_t             req_reg;
    logic [MAX_STREAMS-1:0] hit_reg;
    logic [31:0]      base_reg;
    logic             pre_ok_reg;

    rsp_t             result_reg, result_next;

    // capture-side helpers
    logic [31:0]      cur_cap;

    // commit-side helpers
    logic [31:0]      cur;
    logic [32:0]      sum;
    logic             fit;
    logic             hit_any;
    logic [IDX_W-1:0] slot;
    logic [IDX_W-1:0] last;
    logic [IDX_W-1:0] tail;
    logic             full;
    logic [31:0]      eff_local, eff_peer, expected;
    logic             spent;
    logic             id_bad, role_ok;
    logic [31:0]      new_res;
    logic             res_wr;
    logic [1:0]       status;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            credit_limit_reg <= CREDIT_RST;
            stream_limit_reg <= LIM_CAP;
        end
        else if (cfg_we)
        begin
            unique case (cfg_idx)
                CFG_CREDIT_LIMIT:
                begin
                    credit_limit_reg <= (cfg_data > MAX_WINDOW) ? MAX_WINDOW : cfg_data;
                end
                CFG_STREAM_LIMIT:
                begin
                    stream_limit_reg <= (cfg_data[5:0] > LIM_CAP) ? LIM_CAP : cfg_data[5:0];
                end
                default:
                begin
                end
            endcase
        end
    end

    assign cur_cap = request.direction ? res_in_reg : res_out_reg;

    // parallel id compare is registered at capture; the commit cycle only encodes it
    always_ff @(posedge clk)
    begin
        if (cmd.capture)
        begin
            req_reg <= request;
            for (int i = 0; i < MAX_STREAMS; i++)
            begin
                hit_reg[i] <= (32'(i) < 32'(total_reg)) && (ids_reg[i] == request.sid);
            end
            if (request.op == OP_ADJUST)
            begin
                base_reg   <= cur_cap - request.release_amount;
                pre_ok_reg <= (request.release_amount <= cur_cap);
            end
            else
            begin
                base_reg   <= cur_cap;
                pre_ok_reg <= 1'b1;
            end
        end
    end

    always_comb
    begin
        slot = '0;
        for (int i = 0; i < MAX_STREAMS; i++)
        begin
            if (hit_reg[i])
            begin
                slot = slot | IDX_W'(i);
            end
        end
    end

    assign hit_any = |hit_reg;
    assign last    = IDX_W'(total_reg - CNT_W'(1));
    assign tail    = IDX_W'(total_reg);
    assign full    = (32'(total_reg) >= 32'(stream_limit_reg))
                     || (32'(total_reg) >= 32'(MAX_STREAMS));

    assign cur = req_reg.direction ? res_in_reg : res_out_reg;
    assign sum = {1'b0, base_reg} + {1'b0, req_reg.amount};
    assign fit = pre_ok_reg && (sum <= {1'b0, credit_limit_reg});

    // before the first valid open the expected ids follow from the offered role
    assign eff_local = role_latched_reg ? next_local_reg
                                        : (req_reg.role[0] ? 32'd2 : 32'd1);
    assign eff_peer  = role_latched_reg ? next_peer_reg
                                        : (req_reg.role[0] ? 32'd1 : 32'd2);
    assign expected  = req_reg.local_creates ? eff_local : eff_peer;
    assign spent     = req_reg.local_creates ? local_spent_reg : peer_spent_reg;
    assign id_bad    = (req_reg.sid == 32'd0) || req_reg.role[1];
    assign role_ok   = !role_latched_reg || (latched_role_reg == req_reg.role[0]);

    always_comb
    begin
        role_latched_next = role_latched_reg;
        latched_role_next = latched_role_reg;
        next_local_next   = next_local_reg;
        next_peer_next    = next_peer_reg;
        local_spent_next  = local_spent_reg;
        peer_spent_next   = peer_spent_reg;
        ids_next          = ids_reg;
        total_next        = total_reg;
        res_out_next      = res_out_reg;
        res_in_next       = res_in_reg;
        new_res           = cur;
        res_wr            = 1'b0;
        status            = ST_REJECT;

        case (req_reg.op)
            OP_OPEN:
            begin
                if (!id_bad)
                begin
                    if (!role_latched_reg)
                    begin
                        role_latched_next = 1'b1;
                        latched_role_next = req_reg.role[0];
                        next_local_next   = eff_local;
                        next_peer_next    = eff_peer;
                    end
                    if (role_ok && !spent && (req_reg.sid == expected) && !hit_any)
                    begin
                        if (full)
                        begin
                            status = ST_CAPACITY;
                        end
                        else
                        begin
                            status         = ST_OK;
                            ids_next[tail] = req_reg.sid;
                            total_next     = total_reg + CNT_W'(1);
                        end
                        // a refused local open keeps its id
                        if (!req_reg.local_creates)
                        begin
                            if (expected > ID_LAST)
                            begin
                                peer_spent_next = 1'b1;
                            end
                            else
                            begin
                                next_peer_next = expected + 32'd2;
                            end
                        end
                        else if (!full)
                        begin
                            if (expected > ID_LAST)
                            begin
                                local_spent_next = 1'b1;
                            end
                            else
                            begin
                                next_local_next = expected + 32'd2;
                            end
                        end
                    end
                end
            end
            OP_CLOSE:
            begin
                if (hit_any)
                begin
                    status         = ST_OK;
                    total_next     = total_reg - CNT_W'(1);
                    ids_next[slot] = ids_reg[last];
                    ids_next[last] = 32'd0;
                end
            end
            OP_RESERVE, OP_ADJUST:
            begin
                if (fit)
                begin
                    status  = ST_OK;
                    new_res = sum[31:0];
                    res_wr  = 1'b1;
                end
            end
            OP_RELEASE:
            begin
                if (req_reg.amount <= cur)
                begin
                    status  = ST_OK;
                    new_res = cur - req_reg.amount;
                    res_wr  = 1'b1;
                end
            end
            default:
            begin
                status = ST_REJECT;
            end
        endcase

        if (res_wr)
        begin
            if (req_reg.direction)
            begin
                res_in_next = new_res;
            end
            else
            begin
                res_out_next = new_res;
            end
        end

        result_next.status       = status;
        result_next.active_count = 6'(total_next);
        result_next.reserved_out = res_out_next;
        result_next.reserved_in  = res_in_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            role_latched_reg <= 1'b0;
            latched_role_reg <= 1'b0;
            next_local_reg   <= '0;
            next_peer_reg    <= '0;
            local_spent_reg  <= 1'b0;
            peer_spent_reg   <= 1'b0;
            for (int i = 0; i < MAX_STREAMS; i++)
            begin
                ids_reg[i] <= '0;
            end
            total_reg        <= '0;
            res_out_reg      <= '0;
            res_in_reg       <= '0;
        end
        else if (cmd.commit)
        begin
            role_latched_reg <= role_latched_next;
            latched_role_reg <= latched_role_next;
            next_local_reg   <= next_local_next;
            next_peer_reg    <= next_peer_next;
            local_spent_reg  <= local_spent_next;
            peer_spent_reg   <= peer_spent_next;
            ids_reg          <= ids_next;
            total_reg        <= total_next;
            res_out_reg      <= res_out_next;
            res_in_reg       <= res_in_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.commit)
        begin
            result_reg <= result_next;
        end
    end

    assign result = result_reg;

endmodule

FILE: sv/stream_admission_credit_budget.sv
// A request accepted on start is captured with its id compare registered; the commit
// state then updates the stream state and registers the result and the done strobe.
// A new request is taken only after the id compare and commit stages of the last one.
// The receiver cannot stall: done is high for exactly one cycle per request.
// Reset (rst_n low, asynchronous) clears all streams, ids, credit counts and the
// role latch, and loads the default credit and stream limits.
module stream_admission_credit_budget #(
    parameter int          MAX_STREAMS = sacb_pkg::MAX_STREAMS_DEF,
    parameter logic [31:0] MAX_WINDOW  = sacb_pkg::MAX_WINDOW_DEF
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              start,
    output logic              busy,
    input  sacb_pkg::req_t    request,
    output logic              done,
    output sacb_pkg::rsp_t    result,
    input  logic              cfg_we,
    input  logic              cfg_idx,
    input  logic [31:0]       cfg_data
);
    import sacb_pkg::*;

    cmd_t cmd;

    sacb_ctrl u_ctrl (
        .clk   (clk),
        .rst_n (rst_n),
        .start (start),
        .busy  (busy),
        .done  (done),
        .cmd   (cmd)
    );

    sacb_dp #(
        .MAX_STREAMS (MAX_STREAMS),
        .MAX_WINDOW  (MAX_WINDOW)
    ) u_dp (
        .clk      (clk),
        .rst_n    (rst_n),
        .cmd      (cmd),
        .request  (request),
        .cfg_we   (cfg_we),
        .cfg_idx  (cfg_idx),
        .cfg_data (cfg_data),
        .result   (result)
    );

endmodule
